### hw/rtl/can_frame_id_router_macros.svh
// assertion macros for the can frame id router
`ifndef CAN_FRAME_ID_ROUTER_MACROS_SVH
`define CAN_FRAME_ID_ROUTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CFIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CFIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cfir_pkg.sv
// types and constants shared by the can frame id router modules
package cfir_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [0:0] OP_ROUTE = 1'b0;
  localparam logic [0:0] OP_READ  = 1'b1;

  localparam logic [3:0] DEST_NONE     = 4'd0;
  localparam logic [3:0] DEST_DATA     = 4'd1;
  localparam logic [3:0] DEST_UART_RX  = 4'd2;
  localparam logic [3:0] DEST_OBS_I2C  = 4'd3;
  localparam logic [3:0] DEST_CTRL_I2C = 4'd6;

  localparam int unsigned CNT_NUM = 7;
  localparam logic [2:0] CNT_RX   = 3'd0;
  localparam logic [2:0] CNT_DATA = 3'd1;
  localparam logic [2:0] CNT_I2C  = 3'd2;
  localparam logic [2:0] CNT_UART = 3'd4;
  localparam logic [2:0] CNT_OBS  = 3'd5;
  localparam logic [2:0] CNT_DROP = 3'd6;

  localparam logic [1:0] REG_TYPE_I2C  = 2'd0;
  localparam logic [1:0] REG_TYPE_SPI  = 2'd1;
  localparam logic [1:0] REG_TYPE_UART = 2'd2;

  localparam logic [3:0] MAX_LENGTH = 4'd8;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [28:0] frame_id;
    logic [3:0]  length_code;
    logic        extended_flag;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_six;
    logic [5:0]  full_mask;
    logic [2:0]  counter_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  destination;
    logic [7:0]  target_node;
    logic [3:0]  clamped_length;
    logic        dropped;
    logic [31:0] counter_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0] type_i2c;
    logic [7:0] type_spi;
    logic [7:0] type_uart;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_read;
    logic [2:0] counter_select;
    logic [3:0] destination;
    logic [7:0] target_node;
    logic [3:0] clamped_length;
    logic       dropped;
    logic       bump_route;
    logic [2:0] route_cnt;
  } cls_item_t;

endpackage

### hw/rtl/cfir_front.sv
// front end: classifies each request by identifier, length and payload bytes
module cfir_front (
  input  cfir_pkg::in_item_t  item_i,
  input  cfir_pkg::cfg_t      cfg_i,
  output cfir_pkg::cls_item_t cls_o
);
  import cfir_pkg::*;

  logic [3:0] len;
  logic [7:0] disc_type;
  logic [7:0] node;
  logic       disc_hit;
  logic       hello_hit;
  logic       uart_hit;
  logic       ctrl_hit;
  logic       type_ok;
  logic [1:0] type_cls;
  logic [7:0] type_byte;
  logic       band_ok;
  logic [1:0] band_cls;

  assign len       = (item_i.length_code > MAX_LENGTH) ? MAX_LENGTH : item_i.length_code;
  assign node      = item_i.frame_id[7:0];
  assign disc_type = (item_i.byte_zero == 8'hF0) ? item_i.byte_one : item_i.byte_six;
  assign disc_hit  = (item_i.frame_id == 29'd0) && (len == MAX_LENGTH);
  assign hello_hit = (item_i.frame_id[28:8] == 21'h7) && (len != 4'd0);
  assign uart_hit  = (item_i.frame_id[28:8] == 21'h4);
  assign ctrl_hit  = (item_i.frame_id[28:8] == 21'h1) || (item_i.frame_id[28:8] == 21'h5);
  assign type_byte = disc_hit ? disc_type : item_i.byte_zero;

  always_comb begin
    type_ok  = 1'b1;
    type_cls = 2'd0;
    if (type_byte == cfg_i.type_i2c) begin
      type_cls = 2'd0;
    end else if (type_byte == cfg_i.type_spi) begin
      type_cls = 2'd1;
    end else if (type_byte == cfg_i.type_uart) begin
      type_cls = 2'd2;
    end else begin
      type_ok = 1'b0;
    end
    if (disc_hit && (item_i.byte_zero != 8'hF0) && (item_i.byte_zero != 8'hF2)) begin
      type_ok = 1'b0;
    end
  end

  always_comb begin
    band_ok  = 1'b1;
    band_cls = 2'd0;
    if (node >= 8'h01 && node <= 8'h20) begin
      band_cls = 2'd0;
    end else if (node >= 8'h21 && node <= 8'h30) begin
      band_cls = 2'd1;
    end else if (node >= 8'h31 && node <= 8'h4F) begin
      band_cls = 2'd2;
    end else begin
      band_ok = 1'b0;
    end
  end

  always_comb begin
    cls_o                = '0;
    cls_o.is_read        = (item_i.opcode == OP_READ);
    cls_o.counter_select = item_i.counter_select;
    if (item_i.opcode == OP_ROUTE) begin
      cls_o.clamped_length = len;
      if (disc_hit || hello_hit) begin
        if (type_ok) begin
          cls_o.destination = DEST_OBS_I2C + {2'b00, type_cls};
          cls_o.dropped     = item_i.full_mask[3'd2 + {1'b0, type_cls}];
          cls_o.bump_route  = !cls_o.dropped;
          cls_o.route_cnt   = CNT_OBS;
        end
      end else if (uart_hit) begin
        cls_o.destination = DEST_UART_RX;
        cls_o.dropped     = item_i.full_mask[1];
        cls_o.bump_route  = !cls_o.dropped;
        cls_o.route_cnt   = CNT_UART;
      end else if (ctrl_hit) begin
        if (band_ok) begin
          cls_o.destination = DEST_CTRL_I2C + {2'b00, band_cls};
          cls_o.target_node = node;
          cls_o.dropped     = item_i.full_mask[5];
          cls_o.bump_route  = 1'b1;
          cls_o.route_cnt   = CNT_I2C + {1'b0, band_cls};
        end
      end else begin
        cls_o.destination = DEST_DATA;
        cls_o.dropped     = item_i.full_mask[0];
        cls_o.bump_route  = !cls_o.dropped;
        cls_o.route_cnt   = CNT_DATA;
      end
    end
  end

endmodule

### hw/rtl/cfir_queue.sv
// short fifo between the classifier and the counter stage
module cfir_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfir_pkg::cls_item_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output cfir_pkg::cls_item_t pop_data_o
);
  import cfir_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cls_item_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/cfir_back.sv
// back end: statistics counters and the registered result
module cfir_back #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cfir_pkg::cls_item_t cls_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfir_pkg::out_item_t out_item_o
);
  import cfir_pkg::*;

  logic [COUNTER_WIDTH-1:0]    cnt_q [CNT_NUM];
  logic [COUNTER_WIDTH-1:0]    cnt_d [CNT_NUM];
  logic [CNT_NUM-1:0]          bump;
  logic [COUNTER_WIDTH+31:0]   rd_ext;
  logic                        out_valid_q, out_valid_d;
  out_item_t                   out_item_q, out_item_d;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    bump = '0;
    if (pop_o && !cls_i.is_read) begin
      bump[CNT_RX] = 1'b1;
      if (cls_i.bump_route) begin
        bump[cls_i.route_cnt] = 1'b1;
      end
      if (cls_i.dropped) begin
        bump[CNT_DROP] = 1'b1;
      end
    end
    for (int i = 0; i < CNT_NUM; i++) begin
      cnt_d[i] = bump[i] ? cnt_q[i] + COUNTER_WIDTH'(1) : cnt_q[i];
    end
  end

  assign rd_ext = (cls_i.counter_select < 3'(CNT_NUM)) ?
                  {32'd0, cnt_q[cls_i.counter_select]} : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (pop_o) begin
      out_valid_d                = 1'b1;
      out_item_d.destination     = cls_i.destination;
      out_item_d.target_node     = cls_i.target_node;
      out_item_d.clamped_length  = cls_i.clamped_length;
      out_item_d.dropped         = cls_i.dropped;
      out_item_d.counter_value   = cls_i.is_read ? rd_ext[31:0] : 32'd0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hw/rtl/can_frame_id_router.sv
// top level of the can frame id router
// an accepted request is queued, then popped into the registered result
// throughput: one request per cycle if unstalled, set by single counter stage
// a two-entry queue lets the input keep taking requests while the result waits
// reset clears the counters and the queue and loads type codes 1, 2 and 3
`include "can_frame_id_router_macros.svh"

module can_frame_id_router #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfir_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfir_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cfir_pkg::*;

  cfg_t      cfg_q, cfg_d;
  cls_item_t front_cls;
  cls_item_t q_cls;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_TYPE_I2C:  cfg_d.type_i2c  = pwdata[7:0];
        REG_TYPE_SPI:  cfg_d.type_spi  = pwdata[7:0];
        REG_TYPE_UART: cfg_d.type_uart = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TYPE_I2C:  prdata = {24'd0, cfg_q.type_i2c};
      REG_TYPE_SPI:  prdata = {24'd0, cfg_q.type_spi};
      REG_TYPE_UART: prdata = {24'd0, cfg_q.type_uart};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_i2c  <= 8'd1;
      cfg_q.type_spi  <= 8'd2;
      cfg_q.type_uart <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !q_full;

  cfir_front u_front (
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .cls_o  (front_cls)
  );

  cfir_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cls)
  );

  cfir_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cls_i       (q_cls),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `CFIR_ASSERT_IMP(a_read_no_route, out_valid_o && (out_item_o.counter_value != 32'd0),
    (out_item_o.destination == DEST_NONE) && !out_item_o.dropped, "read result carries a route")
  `CFIR_ASSERT_IMP(a_drop_has_dest, out_valid_o && out_item_o.dropped,
    out_item_o.destination != DEST_NONE, "drop without a destination")
  `CFIR_ASSERT_IMP(a_len_clamped, out_valid_o,
    out_item_o.clamped_length <= MAX_LENGTH, "length above eight")
  `CFIR_ASSERT_NXT(a_accept_yields, in_valid_i && in_ready_o && !q_valid && !out_valid_o,
    q_valid, "accepted request not queued")

endmodule

### tb/can_frame_id_router_tb.sv
// testbench for can_frame_id_router: directed and random requests checked by a built-in routing model
module can_frame_id_router_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfir_pkg::*;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_PCT    = 22;

  localparam logic [7:0]  TAG_TYPE_BYTE1 = 8'hF0;
  localparam logic [7:0]  TAG_TYPE_BYTE6 = 8'hF2;
  localparam logic [20:0] PAGE_STATUS    = 21'h1;
  localparam logic [20:0] PAGE_UART      = 21'h4;
  localparam logic [20:0] PAGE_ACK       = 21'h5;
  localparam logic [20:0] PAGE_HELLO     = 21'h7;
  localparam logic [7:0]  NODE_I2C_LO    = 8'h01;
  localparam logic [7:0]  NODE_I2C_HI    = 8'h20;
  localparam logic [7:0]  NODE_SPI_HI    = 8'h30;
  localparam logic [7:0]  NODE_UART_HI   = 8'h4F;

  class route_board;
    logic [7:0]  type_i2c;
    logic [7:0]  type_spi;
    logic [7:0]  type_uart;
    logic [31:0] stats [CNT_NUM];
    out_item_t   pending_routes [$];
    int unsigned fails;

    function new();
      type_i2c  = 8'd1;
      type_spi  = 8'd2;
      type_uart = 8'd3;
      foreach (stats[i]) stats[i] = '0;
      fails = 0;
    endfunction

    function void set_type(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_TYPE_I2C:  type_i2c = v;
        REG_TYPE_SPI:  type_spi = v;
        REG_TYPE_UART: type_uart = v;
        default: ;
      endcase
    endfunction

    function int type_class(logic [7:0] t);
      if (t == type_i2c) return 0;
      if (t == type_spi) return 1;
      if (t == type_uart) return 2;
      return -1;
    endfunction

    function int node_class(logic [7:0] n);
      if (n >= NODE_I2C_LO && n <= NODE_I2C_HI) return 0;
      if (n > NODE_I2C_HI && n <= NODE_SPI_HI) return 1;
      if (n > NODE_SPI_HI && n <= NODE_UART_HI) return 2;
      return -1;
    endfunction

    function void bump(int which);
      stats[which] = stats[which] + 32'd1;
    endfunction

    function out_item_t route_frame(in_item_t rq);
      out_item_t   r;
      logic [3:0]  len;
      logic [20:0] page;
      int          cls;
      r = '0;
      cls = -1;
      if (rq.opcode == OP_READ) begin
        if (rq.counter_select < CNT_NUM) r.counter_value = stats[rq.counter_select];
        return r;
      end
      len = (rq.length_code > MAX_LENGTH) ? MAX_LENGTH : rq.length_code;
      r.clamped_length = len;
      page = rq.frame_id[28:8];
      bump(CNT_RX);
      if (rq.frame_id == '0 && len == MAX_LENGTH) begin
        if (rq.byte_zero == TAG_TYPE_BYTE1) cls = type_class(rq.byte_one);
        else if (rq.byte_zero == TAG_TYPE_BYTE6) cls = type_class(rq.byte_six);
      end else if (page == PAGE_HELLO && len != 4'd0) begin
        cls = type_class(rq.byte_zero);
      end else if (page == PAGE_UART) begin
        r.destination = DEST_UART_RX;
        r.dropped = rq.full_mask[1];
        bump(r.dropped ? CNT_DROP : CNT_UART);
      end else if (page == PAGE_STATUS || page == PAGE_ACK) begin
        cls = node_class(rq.frame_id[7:0]);
        if (cls >= 0) begin
          r.destination = DEST_CTRL_I2C + 4'(cls);
          r.target_node = rq.frame_id[7:0];
          r.dropped = rq.full_mask[5];
          if (r.dropped) bump(CNT_DROP);
          bump(CNT_I2C + cls);
        end
        return r;
      end else begin
        r.destination = DEST_DATA;
        r.dropped = rq.full_mask[0];
        bump(r.dropped ? CNT_DROP : CNT_DATA);
      end
      // observer route from discovery or hello
      if (cls >= 0) begin
        r.destination = DEST_OBS_I2C + 4'(cls);
        r.dropped = rq.full_mask[2 + cls];
        bump(r.dropped ? CNT_DROP : CNT_OBS);
      end
      return r;
    endfunction

    function void note_request(in_item_t rq);
      pending_routes.push_back(route_frame(rq));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_routes.size() == 0) begin
        $error("result with no request waiting: %h", got);
        fails++;
        return;
      end
      want = pending_routes.pop_front();
      if (got.destination !== want.destination) begin
        $error("destination: expected %0d, got %0d", want.destination, got.destination);
        fails++;
      end
      if (got.target_node !== want.target_node) begin
        $error("target_node: expected %0d, got %0d", want.target_node, got.target_node);
        fails++;
      end
      if (got.clamped_length !== want.clamped_length) begin
        $error("clamped_length: expected %0d, got %0d", want.clamped_length,
               got.clamped_length);
        fails++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
        fails++;
      end
      if (got.counter_value !== want.counter_value) begin
        $error("counter_value: expected %0d, got %0d", want.counter_value,
               got.counter_value);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return pending_routes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  route_board  sb = new();
  bit          calm;
  bit          hold_req;
  int unsigned cycle_count;

  can_frame_id_router u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_item_i);
    end
  end

  // result side: random stalls, optional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 4))
      0: return sb.type_i2c;
      1: return sb.type_spi;
      2: return sb.type_uart;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_node();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 8))
      0: return 8'h00;
      1: return NODE_I2C_LO;
      2: return NODE_I2C_HI;
      3: return NODE_I2C_HI + 8'd1;
      4: return NODE_SPI_HI;
      5: return NODE_SPI_HI + 8'd1;
      6: return NODE_UART_HI;
      7: return NODE_UART_HI + 8'd1;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic in_item_t make_request();
    in_item_t   rq;
    logic [7:0] low;
    rq.opcode         = ($urandom_range(0, 99) < 12) ? OP_READ : OP_ROUTE;
    rq.length_code    = 4'($urandom_range(0, 15));
    rq.extended_flag  = 1'($urandom_range(0, 1));
    rq.byte_zero      = 8'($urandom_range(0, 255));
    rq.byte_one       = pick_type();
    rq.byte_six       = pick_type();
    rq.full_mask      = ($urandom_range(0, 4) < 2) ? 6'($urandom_range(0, 63)) : 6'd0;
    rq.counter_select = 3'($urandom_range(0, 7));
    low = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1: begin
        rq.frame_id = '0;
        if ($urandom_range(0, 3) != 0) rq.length_code = 4'($urandom_range(8, 15));
        case ($urandom_range(0, 2))
          0: rq.byte_zero = TAG_TYPE_BYTE1;
          1: rq.byte_zero = TAG_TYPE_BYTE6;
          default: ;
        endcase
      end
      2: begin
        rq.frame_id = {PAGE_HELLO, low};
        rq.byte_zero = pick_type();
      end
      3: rq.frame_id = {PAGE_UART, low};
      4, 5: rq.frame_id = {($urandom_range(0, 1) != 0) ? PAGE_STATUS : PAGE_ACK, pick_node()};
      6: rq.frame_id = 29'($urandom_range(0, 'h7FF));
      default: rq.frame_id = 29'($urandom);
    endcase
    return rq;
  endfunction

  function automatic in_item_t frame(logic [28:0] id, logic [3:0] len, logic [7:0] b0,
                                     logic [7:0] b1, logic [7:0] b6, logic [5:0] full);
    in_item_t rq;
    rq.opcode         = OP_ROUTE;
    rq.frame_id       = id;
    rq.length_code    = len;
    rq.extended_flag  = (id > 29'h7FF);
    rq.byte_zero      = b0;
    rq.byte_one       = b1;
    rq.byte_six       = b6;
    rq.full_mask      = full;
    rq.counter_select = 3'($urandom_range(0, 7));
    return rq;
  endfunction

  function automatic in_item_t counter_read(logic [2:0] sel);
    in_item_t rq;
    rq = frame(29'($urandom), 4'($urandom_range(0, 15)), 8'hA5, 8'h5A, 8'h3C,
               6'($urandom_range(0, 63)));
    rq.opcode = OP_READ;
    rq.counter_select = sel;
    return rq;
  endfunction

  task automatic push_request(in_item_t rq);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_type(idx, v);
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] t_i2c, logic [7:0] t_spi, logic [7:0] t_uart,
                           bit with_hold, bit quiet);
    write_reg(REG_TYPE_I2C, t_i2c);
    write_reg(REG_TYPE_SPI, t_spi);
    write_reg(REG_TYPE_UART, t_uart);
    calm = quiet;
    if (with_hold) hold_req = 1'b1;
    repeat (PHASE_ITEMS) push_request(make_request());
    drain();
    calm = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    cycle_count = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed requests under the reset type codes
    push_request(frame(29'h0, 4'd8, TAG_TYPE_BYTE1, 8'd1, 8'd0, 6'h00));
    push_request(frame(29'h0, 4'd15, TAG_TYPE_BYTE6, 8'd0, 8'd3, 6'h10));
    push_request(frame(29'h0, 4'd8, 8'h55, 8'd1, 8'd1, 6'h00));
    push_request(frame(29'h0, 4'd7, TAG_TYPE_BYTE1, 8'd1, 8'd0, 6'h00));
    push_request(frame(29'h0, 4'd8, TAG_TYPE_BYTE1, 8'hFF, 8'd0, 6'h00));
    push_request(frame(29'h700, 4'd1, 8'd2, 8'd0, 8'd0, 6'h00));
    push_request(frame(29'h7FF, 4'd0, 8'd2, 8'd0, 8'd0, 6'h01));
    push_request(frame(29'h7A5, 4'd9, 8'hFF, 8'd1, 8'd2, 6'h00));
    push_request(frame(29'h4FF, 4'd3, 8'd0, 8'd0, 8'd0, 6'h02));
    push_request(frame(29'h400, 4'd0, 8'd0, 8'd0, 8'd0, 6'h3D));
    push_request(frame(29'h101, 4'd2, 8'd0, 8'd0, 8'd0, 6'h00));
    push_request(frame(29'h520, 4'd8, 8'd0, 8'd0, 8'd0, 6'h20));
    push_request(frame(29'h121, 4'd5, 8'd0, 8'd0, 8'd0, 6'h1F));
    push_request(frame(29'h54F, 4'd12, 8'd0, 8'd0, 8'd0, 6'h00));
    push_request(frame(29'h150, 4'd4, 8'd0, 8'd0, 8'd0, 6'h3F));
    push_request(frame(29'h100, 4'd4, 8'd0, 8'd0, 8'd0, 6'h00));
    push_request(frame(29'h1FFFFFFF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 6'h01));
    push_request(frame(29'h800, 4'd4, 8'd0, 8'd0, 8'd0, 6'h3E));
    for (int s = 0; s < 8; s++) push_request(counter_read(3'(s)));
    drain();

    run_phase(8'd0, 8'd255, 8'd128, 1'b1, 1'b0);
    run_phase(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    run_phase(8'd7, 8'd7, 8'd7, 1'b0, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0, 1'b0);
    run_phase(8'd1, 8'd2, 8'd3, 1'b1, 1'b0);

    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
